### sv/ssort_pkg.sv
// Package for the stepwise sort engine: sizes, codes and small helper functions.
// Depends on nothing; every other file of the block uses it.
package ssort_pkg;

   // Array geometry.
   localparam int COUNT      = 64;
   localparam int VALUE_BITS = 16;
   localparam int IDX_W      = $clog2(COUNT);
   localparam int POS_W      = IDX_W + 1;
   localparam int STK_W      = POS_W + 1;
   localparam int STK_CAP    = COUNT + 1;
   localparam int STK_AW     = $clog2(STK_CAP);
   localparam int DEP_W      = $clog2(STK_CAP + 1);
   localparam int CNT_W      = 32;

   // Field widths of the channels.
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 6;
   localparam int VALUE_W = 16;
   localparam int STEPS_W = 3;

   // Configuration port.
   localparam int CSR_IW = 1;
   localparam int CSR_DW = 4;
   localparam logic [CSR_IW-1:0] CSR_ALGORITHM = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_SPEED     = 1'd1;

   localparam logic [CSR_DW-1:0] SPEED_MIN   = 4'd1;
   localparam logic [CSR_DW-1:0] SPEED_MAX   = 4'd12;
   localparam logic [CSR_DW-1:0] SPEED_RESET = 4'd7;

   // Function codes of a request.
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   // Sort methods.
   localparam logic [1:0] ALG_BUBBLE = 2'd0;
   localparam logic [1:0] ALG_INSERT = 2'd1;
   localparam logic [1:0] ALG_SELECT = 2'd2;
   localparam logic [1:0] ALG_QUICK  = 2'd3;

   typedef logic [STK_W-1:0] bound_type;

   // Clamp a written speed into its legal range.
   function automatic logic [CSR_DW-1:0] speed_clamp(input logic [CSR_DW-1:0] s);
      logic [CSR_DW-1:0] r;
      r = s;
      if (s < SPEED_MIN) r = SPEED_MIN;
      if (s > SPEED_MAX) r = SPEED_MAX;
      return r;
   endfunction

   // Steps per tick: one plus speed divided by three, as a small table.
   function automatic logic [STEPS_W-1:0] steps_for(input logic [CSR_DW-1:0] s);
      logic [STEPS_W-1:0] r;
      case (s)
         4'd0, 4'd1, 4'd2:    r = 3'd1;
         4'd3, 4'd4, 4'd5:    r = 3'd2;
         4'd6, 4'd7, 4'd8:    r = 3'd3;
         4'd9, 4'd10, 4'd11:  r = 3'd4;
         default:             r = 3'd5;
      endcase
      return r;
   endfunction

   // Saturating increment of an event counter.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

endpackage

### sv/ssort_req_if.sv
// Request channel of the sort engine: valid/ready handshake with func, index and value.
// Depends on ssort_pkg for the field widths.
interface ssort_req_if;
   logic                          valid;
   logic                          ready;
   logic [ssort_pkg::FUNC_W-1:0]  func;
   logic [ssort_pkg::INDEX_W-1:0] index;
   logic [ssort_pkg::VALUE_W-1:0] value;

   modport source (output valid, func, index, value, input ready);
   modport sink   (input valid, func, index, value, output ready);
endinterface

### sv/ssort_rsp_if.sv
// Response channel of the sort engine: valid/ready handshake with the step report.
// Depends on ssort_pkg for the field widths.
interface ssort_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssort_pkg::VALUE_W-1:0] read_value;
   logic [ssort_pkg::INDEX_W-1:0] first_index;
   logic [ssort_pkg::INDEX_W-1:0] second_index;
   logic                          indices_valid;
   logic                          swapped;
   logic                          finished;
   logic [ssort_pkg::CNT_W-1:0]   compare_count;
   logic [ssort_pkg::CNT_W-1:0]   swap_count;
   logic                          last_of_run;

   modport source (output valid, read_value, first_index, second_index, indices_valid,
                   swapped, finished, compare_count, swap_count, last_of_run,
                   input ready);
   modport sink   (input valid, read_value, first_index, second_index, indices_valid,
                   swapped, finished, compare_count, swap_count, last_of_run,
                   output ready);
endinterface

### sv/stepwise_multi_algorithm_sorter.sv
// Stepwise in-place sort engine: element memory, range stack memory and step sequencer.
// Depends on ssort_pkg, ssort_req_if and ssort_rsp_if.
//
// The block holds 64 sixteen-bit elements in a synchronous memory with one write and one
// registered read port and sorts them in place by bubble, insertion, selection or Lomuto
// quicksort, one step per result. A load writes its element and a read waits for the
// registered read data before the result is offered. A tick gives 1 + speed/3 results;
// a comparison step reads both elements (S_RDA, S_RDB, S_EVAL) and a step that swaps
// writes both back as well (S_WRA, S_WRB). In quicksort a step that has to look for the
// next open range pops stack entries (S_POP, S_POPCHK) until one holds more than one
// element. Results sit in an output register, so the sequencer only waits when that
// register is still full. Requests are taken one at a time, when the sequencer is idle.
module stepwise_multi_algorithm_sorter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ssort_pkg::CSR_IW-1:0]   csr_index,
   input  logic [ssort_pkg::CSR_DW-1:0]   csr_wdata,
   ssort_req_if.sink                      req,
   ssort_rsp_if.source                    rsp
);
   import ssort_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDWAIT = 4'd1;
   localparam logic [3:0] S_STEP   = 4'd2;
   localparam logic [3:0] S_POP    = 4'd3;
   localparam logic [3:0] S_POPCHK = 4'd4;
   localparam logic [3:0] S_PUSH   = 4'd5;
   localparam logic [3:0] S_RDA    = 4'd6;
   localparam logic [3:0] S_RDB    = 4'd7;
   localparam logic [3:0] S_EVAL   = 4'd8;
   localparam logic [3:0] S_WRA    = 4'd9;
   localparam logic [3:0] S_WRB    = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;

   localparam logic [POS_W:0] LAST_POS = (POS_W+1)'(COUNT - 1);
   localparam logic [POS_W:0] END_POS  = (POS_W+1)'(COUNT);

   // Memories.
   logic [VALUE_BITS-1:0] elem_mem [COUNT];
   logic [2*STK_W-1:0]    stk_mem  [STK_CAP];

   // Sequencer and sort state.
   logic [3:0]            state_ff, state_in;
   logic [1:0]            alg_ff, alg_in;
   logic [CSR_DW-1:0]     speed_ff, speed_in;
   logic [POS_W-1:0]      outer_ff, outer_in;
   logic [POS_W-1:0]      inner_ff, inner_in;
   logic [POS_W-1:0]      best_ff, best_in;
   logic                  ra_ff, ra_in;
   bound_type             lo_ff, lo_in;
   bound_type             hi_ff, hi_in;
   logic [DEP_W-1:0]      depth_ff, depth_in;
   logic                  fresh_ff, fresh_in;
   logic [CNT_W-1:0]      cmp_ff, cmp_in;
   logic [CNT_W-1:0]      swp_ff, swp_in;
   logic                  sorted_ff, sorted_in;
   logic [STEPS_W-1:0]    steps_ff, steps_in;
   logic [IDX_W-1:0]      a_ff, a_in;
   logic [IDX_W-1:0]      b_ff, b_in;
   logic [VALUE_BITS-1:0] va_ff, va_in;
   logic [VALUE_BITS-1:0] vb_ff, vb_in;
   logic                  cmpmode_ff, cmpmode_in;
   logic                  iv_ff, iv_in;
   logic                  sw_ff, sw_in;
   logic [IDX_W-1:0]      fa_ff, fa_in;
   logic [IDX_W-1:0]      fb_ff, fb_in;
   logic [VALUE_BITS-1:0] rv_ff, rv_in;

   // Output register.
   logic                  ov_ff;
   logic [VALUE_W-1:0]    o_rv_ff;
   logic [INDEX_W-1:0]    o_fa_ff, o_fb_ff;
   logic                  o_iv_ff, o_sw_ff, o_fin_ff, o_last_ff;
   logic [CNT_W-1:0]      o_cmp_ff, o_swp_ff;

   // Memory ports.
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa, rd_addr;
   logic [VALUE_BITS-1:0] mem_wd, rd_data_ff;
   logic                  stk_we;
   logic [STK_AW-1:0]     stk_wa, stk_ra;
   logic [2*STK_W-1:0]    stk_wd, stk_rd_ff;

   logic                  out_free, out_load, do_restart;
   logic [POS_W-1:0]      o_eff, j_eff, b_eff;
   logic [POS_W:0]        sum_w;
   bound_type             ent_lo, ent_hi;

   assign out_free = !ov_ff || rsp.ready;

   // Sequencer next-state logic.
   always_comb begin
      state_in   = state_ff;
      alg_in     = alg_ff;
      speed_in   = speed_ff;
      outer_in   = outer_ff;
      inner_in   = inner_ff;
      best_in    = best_ff;
      ra_in      = ra_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      depth_in   = depth_ff;
      fresh_in   = fresh_ff;
      cmp_in     = cmp_ff;
      swp_in     = swp_ff;
      sorted_in  = sorted_ff;
      steps_in   = steps_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      cmpmode_in = cmpmode_ff;
      iv_in      = iv_ff;
      sw_in      = sw_ff;
      fa_in      = fa_ff;
      fb_in      = fb_ff;
      rv_in      = rv_ff;
      mem_we     = 1'b0;
      mem_wa     = a_ff;
      mem_wd     = vb_ff;
      rd_addr    = a_ff;
      stk_we     = 1'b0;
      stk_wa     = STK_AW'(depth_ff - 1'b1);
      stk_wd     = '0;
      stk_ra     = STK_AW'(depth_ff - 1'b1);
      req.ready  = 1'b0;
      out_load   = 1'b0;
      do_restart = 1'b0;
      o_eff      = outer_ff;
      j_eff      = inner_ff;
      b_eff      = best_ff;
      sum_w      = '0;
      ent_lo     = stk_rd_ff[2*STK_W-1:STK_W];
      ent_hi     = stk_rd_ff[STK_W-1:0];

      case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            rd_addr   = IDX_W'(req.index);
            if (req.valid) begin
               iv_in    = 1'b0;
               sw_in    = 1'b0;
               fa_in    = '0;
               fb_in    = '0;
               rv_in    = '0;
               steps_in = STEPS_W'(1);
               case (req.func)
                  FUNC_LOAD: begin
                     mem_we     = 1'b1;
                     mem_wa     = IDX_W'(req.index);
                     mem_wd     = VALUE_BITS'(req.value);
                     do_restart = 1'b1;
                     state_in   = S_EMIT;
                  end
                  FUNC_TICK: begin
                     steps_in = steps_for(speed_ff);
                     state_in = S_STEP;
                  end
                  FUNC_READ: begin
                     state_in = S_RDWAIT;
                  end
                  default: ;
               endcase
            end
         end

         S_RDWAIT: begin
            rv_in    = rd_data_ff;
            state_in = S_EMIT;
         end

         // Decide what this step does and start its element accesses.
         S_STEP: begin
            iv_in = 1'b0;
            sw_in = 1'b0;
            fa_in = '0;
            fb_in = '0;
            if (sorted_ff) begin
               state_in = S_EMIT;
            end else begin
               case (alg_ff)
                  ALG_BUBBLE: begin
                     if ({1'b0, outer_ff} >= LAST_POS) begin
                        sorted_in = 1'b1;
                        state_in  = S_EMIT;
                     end else begin
                        a_in       = inner_ff[IDX_W-1:0];
                        b_in       = IDX_W'(inner_ff + 1'b1);
                        cmpmode_in = 1'b1;
                        state_in   = S_RDA;
                     end
                  end
                  ALG_INSERT: begin
                     if ({1'b0, outer_ff} >= END_POS) begin
                        sorted_in = 1'b1;
                        state_in  = S_EMIT;
                     end else begin
                        if (outer_ff == '0) begin
                           o_eff = POS_W'(1);
                           j_eff = POS_W'(1);
                        end
                        if (j_eff != '0) begin
                           outer_in   = o_eff;
                           inner_in   = j_eff;
                           a_in       = j_eff[IDX_W-1:0];
                           b_in       = IDX_W'(j_eff - 1'b1);
                           cmpmode_in = 1'b1;
                           state_in   = S_RDA;
                        end else begin
                           sum_w     = {1'b0, o_eff} + 1'b1;
                           outer_in  = POS_W'(sum_w);
                           inner_in  = POS_W'(sum_w);
                           sorted_in = (sum_w >= END_POS);
                           state_in  = S_EMIT;
                        end
                     end
                  end
                  ALG_SELECT: begin
                     if ({1'b0, outer_ff} >= LAST_POS) begin
                        sorted_in = 1'b1;
                        state_in  = S_EMIT;
                     end else begin
                        if (inner_ff == '0 && !ra_ff) begin
                           b_eff = outer_ff;
                           j_eff = outer_ff + 1'b1;
                        end
                        best_in = b_eff;
                        if ({1'b0, j_eff} < END_POS) begin
                           inner_in   = j_eff;
                           a_in       = j_eff[IDX_W-1:0];
                           b_in       = b_eff[IDX_W-1:0];
                           cmpmode_in = 1'b1;
                           state_in   = S_RDA;
                        end else begin
                           outer_in = outer_ff + 1'b1;
                           inner_in = '0;
                           ra_in    = 1'b0;
                           if (b_eff != outer_ff) begin
                              sw_in      = (swp_ff != '1);
                              swp_in     = sat_inc(swp_ff);
                              a_in       = outer_ff[IDX_W-1:0];
                              b_in       = b_eff[IDX_W-1:0];
                              cmpmode_in = 1'b0;
                              state_in   = S_RDA;
                           end else begin
                              state_in = S_EMIT;
                           end
                        end
                     end
                  end
                  default: begin
                     if (!ra_ff) begin
                        state_in = S_POP;
                     end else if ({1'b0, outer_ff} < hi_ff) begin
                        a_in       = outer_ff[IDX_W-1:0];
                        b_in       = hi_ff[IDX_W-1:0];
                        cmpmode_in = 1'b1;
                        state_in   = S_RDA;
                     end else begin
                        // Pivot placement: the range splits around the pivot's slot.
                        sw_in      = (swp_ff != '1);
                        swp_in     = sat_inc(swp_ff);
                        stk_we     = 1'b1;
                        stk_wa     = STK_AW'(depth_ff - 1'b1);
                        stk_wd     = {lo_ff, STK_W'({1'b0, inner_ff}) - 1'b1};
                        if (depth_ff == DEP_W'(1)) fresh_in = 1'b0;
                        ra_in      = 1'b0;
                        a_in       = inner_ff[IDX_W-1:0];
                        b_in       = hi_ff[IDX_W-1:0];
                        cmpmode_in = 1'b0;
                        state_in   = S_PUSH;
                     end
                  end
               endcase
            end
         end

         S_PUSH: begin
            if (depth_ff < DEP_W'(STK_CAP)) begin
               stk_we   = 1'b1;
               stk_wa   = STK_AW'(depth_ff);
               stk_wd   = {STK_W'({1'b0, inner_ff}) + 1'b1, hi_ff};
               depth_in = depth_ff + 1'b1;
            end
            state_in = S_RDA;
         end

         // Pop ranges until one with more than one element turns up.
         S_POP: begin
            if (depth_ff == '0) begin
               sorted_in = 1'b1;
               state_in  = S_EMIT;
            end else begin
               depth_in = depth_ff - 1'b1;
               state_in = S_POPCHK;
            end
         end

         S_POPCHK: begin
            if (depth_ff == '0 && fresh_ff) begin
               ent_lo = '0;
               ent_hi = STK_W'(COUNT - 1);
            end
            if ($signed(ent_lo) < $signed(ent_hi)) begin
               outer_in = POS_W'(ent_lo);
               inner_in = POS_W'(ent_lo);
               best_in  = POS_W'(ent_hi);
               lo_in    = ent_lo;
               hi_in    = ent_hi;
               ra_in    = 1'b1;
               depth_in = depth_ff + 1'b1;
               state_in = S_STEP;
            end else begin
               state_in = S_POP;
            end
         end

         S_RDA: begin
            rd_addr  = a_ff;
            state_in = S_RDB;
         end

         S_RDB: begin
            rd_addr  = b_ff;
            va_in    = rd_data_ff;
            state_in = S_EVAL;
         end

         // Second operand arrives: compare, or go straight to the write-back.
         S_EVAL: begin
            vb_in = rd_data_ff;
            if (!cmpmode_ff) begin
               state_in = S_WRA;
            end else begin
               iv_in  = 1'b1;
               fa_in  = a_ff;
               fb_in  = b_ff;
               cmp_in = sat_inc(cmp_ff);
               case (alg_ff)
                  ALG_BUBBLE: begin
                     sum_w = {1'b0, inner_ff} + 1'b1 + {1'b0, outer_ff};
                     if (sum_w >= LAST_POS) begin
                        inner_in = '0;
                        outer_in = outer_ff + 1'b1;
                     end else begin
                        inner_in = inner_ff + 1'b1;
                     end
                     if (va_ff > rd_data_ff) begin
                        sw_in    = (swp_ff != '1);
                        swp_in   = sat_inc(swp_ff);
                        state_in = S_WRA;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  ALG_INSERT: begin
                     if (va_ff < rd_data_ff) begin
                        sw_in    = (swp_ff != '1);
                        swp_in   = sat_inc(swp_ff);
                        inner_in = inner_ff - 1'b1;
                        state_in = S_WRA;
                     end else begin
                        sum_w     = {1'b0, outer_ff} + 1'b1;
                        outer_in  = POS_W'(sum_w);
                        inner_in  = POS_W'(sum_w);
                        sorted_in = (sum_w >= END_POS);
                        state_in  = S_EMIT;
                     end
                  end
                  ALG_SELECT: begin
                     if (va_ff < rd_data_ff) best_in = POS_W'(a_ff);
                     inner_in = inner_ff + 1'b1;
                     state_in = S_EMIT;
                  end
                  default: begin
                     outer_in = outer_ff + 1'b1;
                     state_in = S_EMIT;
                     if (va_ff < rd_data_ff) begin
                        inner_in = inner_ff + 1'b1;
                        if (outer_ff != inner_ff) begin
                           sw_in      = (swp_ff != '1);
                           swp_in     = sat_inc(swp_ff);
                           a_in       = outer_ff[IDX_W-1:0];
                           b_in       = inner_ff[IDX_W-1:0];
                           cmpmode_in = 1'b0;
                           state_in   = S_RDA;
                        end
                     end
                  end
               endcase
            end
         end

         S_WRA: begin
            mem_we   = 1'b1;
            mem_wa   = a_ff;
            mem_wd   = vb_ff;
            state_in = S_WRB;
         end

         S_WRB: begin
            mem_we   = 1'b1;
            mem_wa   = b_ff;
            mem_wd   = va_ff;
            state_in = S_EMIT;
         end

         // Hand the report to the output register, then run the next step if any.
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (steps_ff > STEPS_W'(1)) begin
                  steps_in = steps_ff - 1'b1;
                  state_in = S_STEP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Configuration writes; the algorithm register restarts the sorter.
      if (csr_we) begin
         case (csr_index)
            CSR_ALGORITHM: begin
               alg_in     = csr_wdata[1:0];
               do_restart = 1'b1;
            end
            CSR_SPEED: speed_in = speed_clamp(csr_wdata);
            default: ;
         endcase
      end

      if (do_restart) begin
         outer_in  = '0;
         inner_in  = '0;
         ra_in     = 1'b0;
         best_in   = '0;
         depth_in  = DEP_W'(1);
         fresh_in  = 1'b1;
         cmp_in    = '0;
         swp_in    = '0;
         sorted_in = 1'b0;
      end
   end

   // Control and sort state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         alg_ff    <= ALG_BUBBLE;
         speed_ff  <= SPEED_RESET;
         outer_ff  <= '0;
         inner_ff  <= '0;
         best_ff   <= '0;
         ra_ff     <= 1'b0;
         depth_ff  <= DEP_W'(1);
         fresh_ff  <= 1'b1;
         cmp_ff    <= '0;
         swp_ff    <= '0;
         sorted_ff <= 1'b0;
         steps_ff  <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         alg_ff    <= alg_in;
         speed_ff  <= speed_in;
         outer_ff  <= outer_in;
         inner_ff  <= inner_in;
         best_ff   <= best_in;
         ra_ff     <= ra_in;
         depth_ff  <= depth_in;
         fresh_ff  <= fresh_in;
         cmp_ff    <= cmp_in;
         swp_ff    <= swp_in;
         sorted_ff <= sorted_in;
         steps_ff  <= steps_in;
         if (out_load)       ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      cmpmode_ff <= cmpmode_in;
      iv_ff      <= iv_in;
      sw_ff      <= sw_in;
      fa_ff      <= fa_in;
      fb_ff      <= fb_in;
      rv_ff      <= rv_in;
      if (out_load) begin
         o_rv_ff   <= VALUE_W'(rv_ff);
         o_fa_ff   <= INDEX_W'(fa_ff);
         o_fb_ff   <= INDEX_W'(fb_ff);
         o_iv_ff   <= iv_ff;
         o_sw_ff   <= sw_ff;
         o_fin_ff  <= sorted_ff;
         o_cmp_ff  <= cmp_ff;
         o_swp_ff  <= swp_ff;
         o_last_ff <= (steps_ff == STEPS_W'(1));
      end
   end

   // Element memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) elem_mem[mem_wa] <= mem_wd;
      rd_data_ff <= elem_mem[rd_addr];
   end

   // Range stack memory: lower bound in the upper half of each entry.
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stk_mem[stk_ra];
   end

   assign rsp.valid         = ov_ff;
   assign rsp.read_value    = o_rv_ff;
   assign rsp.first_index   = o_fa_ff;
   assign rsp.second_index  = o_fb_ff;
   assign rsp.indices_valid = o_iv_ff;
   assign rsp.swapped       = o_sw_ff;
   assign rsp.finished      = o_fin_ff;
   assign rsp.compare_count = o_cmp_ff;
   assign rsp.swap_count    = o_swp_ff;
   assign rsp.last_of_run   = o_last_ff;

endmodule
